@@ sv/kvf_pkg.sv @@
// shared types, constants and micro-program of the height/velocity kalman filter
package kvf_pkg;

  localparam int VW     = 32;
  localparam int FB     = 16;
  localparam int PROD_W = 2 * VW;
  localparam int MAG_W  = PROD_W - FB + 1;
  localparam int NUM_W  = VW + FB;
  localparam int PC_W   = 5;
  localparam int SRC_W  = 5;

  typedef logic signed [VW-1:0] val_t;

  localparam val_t VMAX   = {1'b0, {(VW-1){1'b1}}};
  localparam val_t VMIN   = {1'b1, {(VW-1){1'b0}}};
  localparam val_t ONE_Q  = val_t'(64'd1 << FB);
  localparam val_t HALF_Q = val_t'(64'd1 << (FB - 1));

  // configuration register indexes
  localparam logic [1:0] CFG_DT = 2'd0;
  localparam logic [1:0] CFG_Q  = 2'd1;
  localparam logic [1:0] CFG_R  = 2'd2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // working register codes
  localparam logic [SRC_W-1:0] R_DT   = 5'd0;
  localparam logic [SRC_W-1:0] R_Q    = 5'd1;
  localparam logic [SRC_W-1:0] R_R    = 5'd2;
  localparam logic [SRC_W-1:0] R_A    = 5'd3;
  localparam logic [SRC_W-1:0] R_Y    = 5'd4;
  localparam logic [SRC_W-1:0] R_B0   = 5'd5;
  localparam logic [SRC_W-1:0] R_T    = 5'd6;
  localparam logic [SRC_W-1:0] R_U    = 5'd7;
  localparam logic [SRC_W-1:0] R_H    = 5'd8;
  localparam logic [SRC_W-1:0] R_V    = 5'd9;
  localparam logic [SRC_W-1:0] R_T01  = 5'd10;
  localparam logic [SRC_W-1:0] R_P00  = 5'd11;
  localparam logic [SRC_W-1:0] R_P11  = 5'd12;
  localparam logic [SRC_W-1:0] R_E    = 5'd13;
  localparam logic [SRC_W-1:0] R_S    = 5'd14;
  localparam logic [SRC_W-1:0] R_K0   = 5'd15;
  localparam logic [SRC_W-1:0] R_K1   = 5'd16;
  localparam logic [SRC_W-1:0] R_KS0  = 5'd17;
  localparam logic [SRC_W-1:0] R_KS1  = 5'd18;
  localparam logic [SRC_W-1:0] R_EH   = 5'd19;
  localparam logic [SRC_W-1:0] R_EV   = 5'd20;
  localparam logic [SRC_W-1:0] R_CH   = 5'd21;
  localparam logic [SRC_W-1:0] R_CC   = 5'd22;
  localparam logic [SRC_W-1:0] R_CV   = 5'd23;
  localparam logic [SRC_W-1:0] R_HALF = 5'd24;

  localparam logic [PC_W-1:0] PC_K0   = 5'd18;
  localparam logic [PC_W-1:0] PC_LAST = 5'd31;

  typedef struct packed {
    logic [1:0]       op;
    logic [SRC_W-1:0] sx;
    logic [SRC_W-1:0] sy;
    logic [SRC_W-1:0] dst;
  } uop_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

  function automatic uop_t mk(input logic [1:0] op, input logic [SRC_W-1:0] dst,
                              input logic [SRC_W-1:0] sx, input logic [SRC_W-1:0] sy);
    uop_t u;
    u.op = op; u.sx = sx; u.sy = sy; u.dst = dst;
    return u;
  endfunction

  function automatic uop_t get_uop(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      5'd0:  u = mk(OP_MUL, R_T,   R_DT,  R_DT);
      5'd1:  u = mk(OP_MUL, R_B0,  R_T,   R_HALF);
      5'd2:  u = mk(OP_MUL, R_T,   R_DT,  R_EV);
      5'd3:  u = mk(OP_ADD, R_T,   R_EH,  R_T);
      5'd4:  u = mk(OP_MUL, R_U,   R_B0,  R_A);
      5'd5:  u = mk(OP_ADD, R_H,   R_T,   R_U);
      5'd6:  u = mk(OP_MUL, R_T,   R_DT,  R_A);
      5'd7:  u = mk(OP_ADD, R_V,   R_EV,  R_T);
      5'd8:  u = mk(OP_MUL, R_T,   R_DT,  R_CV);
      5'd9:  u = mk(OP_ADD, R_T01, R_CC,  R_T);
      5'd10: u = mk(OP_MUL, R_T,   R_DT,  R_CC);
      5'd11: u = mk(OP_ADD, R_U,   R_CH,  R_T);
      5'd12: u = mk(OP_MUL, R_T,   R_DT,  R_T01);
      5'd13: u = mk(OP_ADD, R_T,   R_U,   R_T);
      5'd14: u = mk(OP_ADD, R_P00, R_T,   R_Q);
      5'd15: u = mk(OP_ADD, R_P11, R_CV,  R_Q);
      5'd16: u = mk(OP_SUB, R_E,   R_Y,   R_H);
      5'd17: u = mk(OP_ADD, R_S,   R_P00, R_R);
      5'd18: u = mk(OP_DIV, R_K0,  R_P00, R_S);
      5'd19: u = mk(OP_DIV, R_K1,  R_T01, R_S);
      5'd20: u = mk(OP_MUL, R_KS0, R_K0,  R_S);
      5'd21: u = mk(OP_MUL, R_KS1, R_K1,  R_S);
      5'd22: u = mk(OP_MUL, R_T,   R_K0,  R_E);
      5'd23: u = mk(OP_ADD, R_EH,  R_H,   R_T);
      5'd24: u = mk(OP_MUL, R_T,   R_K1,  R_E);
      5'd25: u = mk(OP_ADD, R_EV,  R_V,   R_T);
      5'd26: u = mk(OP_MUL, R_T,   R_KS0, R_K0);
      5'd27: u = mk(OP_SUB, R_CH,  R_P00, R_T);
      5'd28: u = mk(OP_MUL, R_T,   R_KS0, R_K1);
      5'd29: u = mk(OP_SUB, R_CC,  R_T01, R_T);
      5'd30: u = mk(OP_MUL, R_T,   R_KS1, R_K1);
      5'd31: u = mk(OP_SUB, R_CV,  R_P11, R_T);
      default: u = mk(OP_ADD, R_T, R_T, R_T);
    endcase
    return u;
  endfunction

  function automatic logic [VW-1:0] magn(input val_t v);
    return v[VW-1] ? (~v + 1'b1) : v;
  endfunction

  // clamp a signed magnitude into range, msb of the result is the clamp flag
  function automatic logic [VW:0] fit(input logic neg, input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] lim;
    logic [VW-1:0]    lo;
    lim = neg ? MAG_W'(64'd1 << (VW - 1)) : MAG_W'((64'd1 << (VW - 1)) - 1);
    lo  = mag[VW-1:0];
    if (mag > lim) return {1'b1, neg ? VMIN : VMAX};
    return {1'b0, neg ? (~lo + 1'b1) : lo};
  endfunction

endpackage

@@ sv/kvf_in_if.sv @@
// request channel carrying acceleration and height samples
interface kvf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] accel_z;
  logic signed [31:0] measured_height;
  modport source(output valid, accel_z, measured_height, input ready);
  modport sink(input valid, accel_z, measured_height, output ready);
endinterface

@@ sv/kvf_out_if.sv @@
// result channel carrying prior and posterior estimates
interface kvf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] prior_height;
  logic signed [31:0] posterior_height;
  logic signed [31:0] posterior_velocity;
  logic               arith_flag;
  modport source(output valid, prior_height, posterior_height, posterior_velocity, arith_flag,
                 input ready);
  modport sink(input valid, prior_height, posterior_height, posterior_velocity, arith_flag,
               output ready);
endinterface

@@ sv/height_velocity_kalman_filter.sv @@
// two-state height/velocity kalman filter on a shared alu and a serial divider
// when s is zero the divides and the correction are skipped and the prediction is the result
// an alu step passes the issue and writeback states, each of the two divides the issue and divide states
// one request at a time, none taken until the result is in the output register; the 48-step divider dominates
// synchronous active-low reset: state to zero with unit covariance, config registers to defaults
module height_velocity_kalman_filter
  import kvf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  kvf_in_if.sink           in_ch,
  kvf_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_wdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ISSUE  = 3'd1;
  localparam logic [2:0] ST_WB     = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]      state_r;
  logic [PC_W-1:0] pc_r;
  logic            flag_r;

  logic [15:0] time_step_r;
  logic [31:0] pvar_r;
  logic [31:0] svar_r;

  val_t dt_r, q_r, r_r, a_r, y_r, b0_r, t_r, u_r, h_r, v_r, t01_r, p00_r, p11_r;
  val_t e_r, s_r, k0_r, k1_r, ks0_r, ks1_r, eh_r, ev_r, ch_r, cc_r, cv_r;

  logic out_valid_r;
  val_t out_prior_r, out_h_r, out_v_r;
  logic out_flag_r;

  uop_t     u;
  val_t     opx, opy;
  alu_req_t alu_req;
  val_t     alu_res;
  logic     alu_ovf;
  logic     div_start;
  logic     div_done;
  val_t     div_quo;
  logic     div_ovf;
  logic     in_acc;
  logic     zero_s;
  logic     wb_en;
  val_t     wb_val;

  assign u      = get_uop(pc_r);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign zero_s = (state_r == ST_ISSUE) && (u.op == OP_DIV) && (pc_r == PC_K0) && (s_r == '0);

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    unique case (u.sx)
      R_DT:    opx = dt_r;
      R_Q:     opx = q_r;
      R_R:     opx = r_r;
      R_A:     opx = a_r;
      R_Y:     opx = y_r;
      R_B0:    opx = b0_r;
      R_T:     opx = t_r;
      R_U:     opx = u_r;
      R_H:     opx = h_r;
      R_V:     opx = v_r;
      R_T01:   opx = t01_r;
      R_P00:   opx = p00_r;
      R_P11:   opx = p11_r;
      R_E:     opx = e_r;
      R_S:     opx = s_r;
      R_K0:    opx = k0_r;
      R_K1:    opx = k1_r;
      R_KS0:   opx = ks0_r;
      R_KS1:   opx = ks1_r;
      R_EH:    opx = eh_r;
      R_EV:    opx = ev_r;
      R_CH:    opx = ch_r;
      R_CC:    opx = cc_r;
      R_CV:    opx = cv_r;
      default: opx = HALF_Q;
    endcase
  end

  always_comb begin
    unique case (u.sy)
      R_DT:    opy = dt_r;
      R_Q:     opy = q_r;
      R_R:     opy = r_r;
      R_A:     opy = a_r;
      R_Y:     opy = y_r;
      R_B0:    opy = b0_r;
      R_T:     opy = t_r;
      R_U:     opy = u_r;
      R_H:     opy = h_r;
      R_V:     opy = v_r;
      R_T01:   opy = t01_r;
      R_P00:   opy = p00_r;
      R_P11:   opy = p11_r;
      R_E:     opy = e_r;
      R_S:     opy = s_r;
      R_K0:    opy = k0_r;
      R_K1:    opy = k1_r;
      R_KS0:   opy = ks0_r;
      R_KS1:   opy = ks1_r;
      R_EH:    opy = eh_r;
      R_EV:    opy = ev_r;
      R_CH:    opy = ch_r;
      R_CC:    opy = cc_r;
      R_CV:    opy = cv_r;
      default: opy = HALF_Q;
    endcase
  end

  assign alu_req.start = (state_r == ST_ISSUE) && (u.op != OP_DIV);
  assign alu_req.op    = u.op;
  assign div_start     = (state_r == ST_ISSUE) && (u.op == OP_DIV) && !zero_s;

  kvf_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .x   (opx),
    .y   (opy),
    .res (alu_res),
    .ovf (alu_ovf)
  );

  kvf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (opx),
    .den   (opy),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  assign wb_en  = (state_r == ST_WB) || ((state_r == ST_DIV) && div_done);
  assign wb_val = (state_r == ST_WB) ? alu_res : div_quo;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_ISSUE;
            pc_r    <= '0;
          end
        end
        ST_ISSUE: begin
          if (zero_s) state_r <= ST_FINISH;
          else if (u.op == OP_DIV) state_r <= ST_DIV;
          else state_r <= ST_WB;
        end
        ST_WB, ST_DIV: begin
          if (wb_en) begin
            pc_r    <= pc_r + 1'b1;
            state_r <= (pc_r == PC_LAST) ? ST_FINISH : ST_ISSUE;
          end
        end
        ST_FINISH: begin
          if (!out_valid_r || out_ch.ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= 16'd655;
      pvar_r      <= 32'd164;
      svar_r      <= 32'd5898;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DT:  time_step_r <= cfg_wdata[15:0];
        CFG_Q:   pvar_r      <= cfg_wdata;
        CFG_R:   svar_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else if (in_acc) begin
      flag_r <= pvar_r[31] | svar_r[31];
    end else if (zero_s) begin
      flag_r <= 1'b1;
    end else if (wb_en) begin
      flag_r <= flag_r | ((state_r == ST_WB) ? alu_ovf : div_ovf);
    end
  end

  // filter state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eh_r <= '0;
      ev_r <= '0;
      ch_r <= ONE_Q;
      cc_r <= '0;
      cv_r <= ONE_Q;
    end else if (in_acc) begin
      dt_r <= {16'd0, time_step_r};
      q_r  <= pvar_r[31] ? VMAX : pvar_r;
      r_r  <= svar_r[31] ? VMAX : svar_r;
      a_r  <= in_ch.accel_z;
      y_r  <= in_ch.measured_height;
    end else if (zero_s) begin
      // correction skipped, posterior is the prediction
      eh_r <= h_r;
      ev_r <= v_r;
      ch_r <= p00_r;
      cc_r <= t01_r;
      cv_r <= p11_r;
    end else if (wb_en) begin
      unique case (u.dst)
        R_B0:    b0_r  <= wb_val;
        R_T:     t_r   <= wb_val;
        R_U:     u_r   <= wb_val;
        R_H:     h_r   <= wb_val;
        R_V:     v_r   <= wb_val;
        R_T01:   t01_r <= wb_val;
        R_P00:   p00_r <= wb_val;
        R_P11:   p11_r <= wb_val;
        R_E:     e_r   <= wb_val;
        R_S:     s_r   <= wb_val;
        R_K0:    k0_r  <= wb_val;
        R_K1:    k1_r  <= wb_val;
        R_KS0:   ks0_r <= wb_val;
        R_KS1:   ks1_r <= wb_val;
        R_EH:    eh_r  <= wb_val;
        R_EV:    ev_r  <= wb_val;
        R_CH:    ch_r  <= wb_val;
        R_CC:    cc_r  <= wb_val;
        R_CV:    cv_r  <= wb_val;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FINISH && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && (!out_valid_r || out_ch.ready)) begin
      out_prior_r <= h_r;
      out_h_r     <= eh_r;
      out_v_r     <= ev_r;
      out_flag_r  <= flag_r;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.prior_height       = out_prior_r;
  assign out_ch.posterior_height   = out_h_r;
  assign out_ch.posterior_velocity = out_v_r;
  assign out_ch.arith_flag         = out_flag_r;

endmodule

@@ sv/kvf_alu.sv @@
// shared saturating add/sub and rounding fixed point multiplier, one register stage
module kvf_alu
  import kvf_pkg::*;
(
  input  logic     clk,
  input  alu_req_t req,
  input  val_t     x,
  input  val_t     y,
  output val_t     res,
  output logic     ovf
);

  logic              mul_r;
  logic              neg_r;
  logic [PROD_W-1:0] prod_r;
  logic [VW:0]       sum_r;
  logic [PROD_W-1:0] rnd;
  logic [VW:0]       fr;

  always_ff @(posedge clk) begin
    if (req.start) begin
      mul_r  <= (req.op == OP_MUL);
      neg_r  <= x[VW-1] ^ y[VW-1];
      prod_r <= PROD_W'(magn(x)) * PROD_W'(magn(y));
      sum_r  <= (req.op == OP_SUB) ? ({x[VW-1], x} - {y[VW-1], y})
                                   : ({x[VW-1], x} + {y[VW-1], y});
    end
  end

  always_comb begin
    rnd = prod_r + PROD_W'(HALF_Q);
    fr  = fit(neg_r, {1'b0, rnd[PROD_W-1:FB]});
    if (mul_r) begin
      res = fr[VW-1:0];
      ovf = fr[VW];
    end else if (sum_r[VW] != sum_r[VW-1]) begin
      res = sum_r[VW] ? VMIN : VMAX;
      ovf = 1'b1;
    end else begin
      res = sum_r[VW-1:0];
      ovf = 1'b0;
    end
  end

endmodule

@@ sv/kvf_div.sv @@
// radix-2 restoring divider for fixed point quotients, rounded to nearest
module kvf_div
  import kvf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  val_t num,
  input  val_t den,
  output logic done,
  output val_t quo,
  output logic ovf
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [VW-1:0]    rem_r;
  logic [VW-1:0]    d_r;
  logic             neg_r;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             ge;
  logic             up;
  logic [VW:0]      fr;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {magn(num), {FB{1'b0}}};
      d_r   <= magn(den);
      rem_r <= '0;
      quo_r <= '0;
      neg_r <= num[VW-1] ^ den[VW-1];
    end else if (busy_r) begin
      rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
      num_r <= num_r << 1;
    end
  end

  // round half up on the magnitude
  always_comb begin
    up = rem_r >= (d_r - rem_r);
    fr = fit(neg_r, MAG_W'(quo_r) + MAG_W'(up));
  end

  assign done = done_r;
  assign quo  = fr[VW-1:0];
  assign ovf  = fr[VW];

endmodule

@@ sv/kvf_checker.sv @@
// port-level checker for the kalman filter, bound to the top level
module kvf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_flag
);

  // one request at a time: busy right after taking one
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a new result appears only when the block was working
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_flag))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear handshake");

endmodule

bind height_velocity_kalman_filter kvf_checker u_kvf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_flag  (out_ch.arith_flag)
);
